>>> design/hpv_pkg.sv
`default_nettype none
package hpv_pkg;

   localparam int PHASE_BITS    = 32;
   localparam int TRIG_BITS     = 34;
   localparam int RESID_BITS    = PHASE_BITS + 1;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic signed [TRIG_BITS-1:0] GAIN_INV = 34'sd652032874;
   localparam logic signed [TRIG_BITS-1:0] ONE_Q30  = 34'sd1073741824;
   localparam logic [PHASE_BITS-1:0]       HALF_QUADRANT = 32'h2000_0000;

   localparam logic [PHASE_BITS-1:0] ATAN_PHASE [32] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,
      32'd41,        32'd20,        32'd10,        32'd5,
      32'd3,         32'd1,         32'd1,         32'd0
   };

   typedef enum logic [1:0] {
      QUAD_0   = 2'd0,
      QUAD_90  = 2'd1,
      QUAD_180 = 2'd2,
      QUAD_270 = 2'd3
   } hpv_quad_type;

   typedef enum logic {
      REG_FWD_Z_NEG = 1'b0,
      REG_PITCH_EN  = 1'b1
   } hpv_reg_type;

   typedef struct packed {
      logic forward_z_negative;
      logic pitch_enable;
   } hpv_cfg_type;

endpackage
`default_nettype wire

>>> design/hpv_if.sv
`default_nettype none
interface hpv_req_if #(
   parameter int ANGLE_BITS = 16,
   parameter int DATA_BITS  = 16
);
   logic                        valid;
   logic                        ready;
   logic [ANGLE_BITS-1:0]       heading_angle;
   logic [ANGLE_BITS-1:0]       pitch_angle;
   logic signed [DATA_BITS-1:0] speed;

   modport source (output valid, heading_angle, pitch_angle, speed, input ready);
   modport sink (input valid, heading_angle, pitch_angle, speed, output ready);
endinterface

interface hpv_rsp_if #(
   parameter int DATA_BITS = 16
);
   logic                        valid;
   logic                        ready;
   logic signed [DATA_BITS-1:0] step_x;
   logic signed [DATA_BITS-1:0] step_y;
   logic signed [DATA_BITS-1:0] step_z;

   modport source (output valid, step_x, step_y, step_z, input ready);
   modport sink (input valid, step_x, step_y, step_z, output ready);
endinterface
`default_nettype wire

>>> design/hpv_csr.sv
`default_nettype none
module hpv_csr (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic [hpv_pkg::CSR_ADDR_BITS-1:0]     paddr,
   input  wire logic [hpv_pkg::CSR_DATA_BITS-1:0]     pwdata,
   output logic      [hpv_pkg::CSR_DATA_BITS-1:0]     prdata,
   output logic                                       pready,
   output hpv_pkg::hpv_cfg_type                       cfg_o
);
   import hpv_pkg::*;

   hpv_cfg_type cfg_ff, cfg_in;
   hpv_reg_type reg_sel;
   logic        wr_en;

   assign reg_sel = hpv_reg_type'(paddr[2]);
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;
   assign cfg_o   = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      prdata = '0;
      unique case (reg_sel)
         REG_FWD_Z_NEG: begin
            prdata[0] = cfg_ff.forward_z_negative;
            if (wr_en) begin
               cfg_in.forward_z_negative = pwdata[0];
            end
         end
         REG_PITCH_EN: begin
            prdata[0] = cfg_ff.pitch_enable;
            if (wr_en) begin
               cfg_in.pitch_enable = pwdata[0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.forward_z_negative <= 1'b0;
         cfg_ff.pitch_enable       <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

>>> design/hpv_cordic.sv
`default_nettype none
module hpv_cordic #(
   parameter int ANGLE_BITS      = 16,
   parameter int ROTATION_STAGES = 16
) (
   input  wire logic                                    clock,
   input  wire logic [ANGLE_BITS-1:0]                   angle_i,
   output logic signed [hpv_pkg::TRIG_BITS-1:0]         cos_o,
   output logic signed [hpv_pkg::TRIG_BITS-1:0]         sin_o
);
   import hpv_pkg::*;

   logic signed [TRIG_BITS-1:0]  x_ff [ROTATION_STAGES+1];
   logic signed [TRIG_BITS-1:0]  x_in [ROTATION_STAGES+1];
   logic signed [TRIG_BITS-1:0]  y_ff [ROTATION_STAGES+1];
   logic signed [TRIG_BITS-1:0]  y_in [ROTATION_STAGES+1];
   logic signed [RESID_BITS-1:0] z_ff [ROTATION_STAGES+1];
   logic signed [RESID_BITS-1:0] z_in [ROTATION_STAGES+1];
   hpv_quad_type                 q_ff [ROTATION_STAGES+1];
   hpv_quad_type                 q_in [ROTATION_STAGES+1];
   logic                         zero_ff [ROTATION_STAGES+1];
   logic                         zero_in [ROTATION_STAGES+1];

   logic [PHASE_BITS-1:0] phase, phase_rnd, resid;
   hpv_quad_type          quad;

   logic signed [TRIG_BITS-1:0] cos_ff, cos_in, sin_ff, sin_in;
   logic signed [TRIG_BITS-1:0] xr, yr;

   // quadrant fold
   assign phase     = {angle_i, {(PHASE_BITS-ANGLE_BITS){1'b0}}};
   assign phase_rnd = phase + HALF_QUADRANT;
   assign quad      = hpv_quad_type'(phase_rnd[PHASE_BITS-1 -: 2]);
   assign resid     = phase - {quad, {(PHASE_BITS-2){1'b0}}};

   assign x_in[0]    = GAIN_INV;
   assign y_in[0]    = '0;
   assign z_in[0]    = {resid[PHASE_BITS-1], resid};
   assign q_in[0]    = quad;
   assign zero_in[0] = (resid == '0);

   for (genvar i = 0; i < ROTATION_STAGES; i++) begin : g_stage
      logic signed [TRIG_BITS-1:0]  xs, ys;
      logic signed [RESID_BITS-1:0] step;
      logic                         neg;

      assign xs   = x_ff[i] >>> i;
      assign ys   = y_ff[i] >>> i;
      assign step = {1'b0, ATAN_PHASE[i]};
      assign neg  = z_ff[i][RESID_BITS-1];

      assign x_in[i+1]    = neg ? x_ff[i] + ys : x_ff[i] - ys;
      assign y_in[i+1]    = neg ? y_ff[i] - xs : y_ff[i] + xs;
      assign z_in[i+1]    = neg ? z_ff[i] + step : z_ff[i] - step;
      assign q_in[i+1]    = q_ff[i];
      assign zero_in[i+1] = zero_ff[i];
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i <= ROTATION_STAGES; i++) begin
         x_ff[i]    <= x_in[i];
         y_ff[i]    <= y_in[i];
         z_ff[i]    <= z_in[i];
         q_ff[i]    <= q_in[i];
         zero_ff[i] <= zero_in[i];
      end
   end

   // axis angles skip the rotation result
   assign xr = zero_ff[ROTATION_STAGES] ? ONE_Q30 : x_ff[ROTATION_STAGES];
   assign yr = zero_ff[ROTATION_STAGES] ? '0 : y_ff[ROTATION_STAGES];

   always_comb begin
      case (q_ff[ROTATION_STAGES])
         QUAD_0: begin
            cos_in = xr;
            sin_in = yr;
         end
         QUAD_90: begin
            cos_in = -yr;
            sin_in = xr;
         end
         QUAD_180: begin
            cos_in = -xr;
            sin_in = -yr;
         end
         default: begin
            cos_in = yr;
            sin_in = -xr;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cos_ff <= cos_in;
      sin_ff <= sin_in;
   end

   assign cos_o = cos_ff;
   assign sin_o = sin_ff;

endmodule
`default_nettype wire

>>> design/hpv_scale.sv
`default_nettype none
module hpv_scale #(
   parameter int DATA_BITS = 16
) (
   input  wire logic                                clock,
   input  wire hpv_pkg::hpv_cfg_type                cfg_i,
   input  wire logic signed [DATA_BITS-1:0]         speed_i,
   input  wire logic signed [hpv_pkg::TRIG_BITS-1:0] head_cos_i,
   input  wire logic signed [hpv_pkg::TRIG_BITS-1:0] head_sin_i,
   input  wire logic signed [hpv_pkg::TRIG_BITS-1:0] pitch_sin_i,
   output logic signed [DATA_BITS-1:0]              step_x_o,
   output logic signed [DATA_BITS-1:0]              step_y_o,
   output logic signed [DATA_BITS-1:0]              step_z_o
);
   import hpv_pkg::*;

   localparam int PW = DATA_BITS + TRIG_BITS;
   localparam int RW = PW - 30;
   localparam logic signed [PW-1:0] RND = PW'(64'd1 << 29);
   localparam logic signed [RW-1:0] HI  = {{(RW-DATA_BITS+1){1'b0}}, {(DATA_BITS-1){1'b1}}};
   localparam logic signed [RW-1:0] LO  = {{(RW-DATA_BITS+1){1'b1}}, {(DATA_BITS-1){1'b0}}};

   function automatic logic signed [DATA_BITS-1:0] round_sat(input logic signed [PW-1:0] p);
      logic signed [PW-1:0] sum;
      logic signed [RW-1:0] r;
      sum = p + RND;
      r   = RW'(sum >>> 30);
      if (r > HI) begin
         return HI[DATA_BITS-1:0];
      end else if (r < LO) begin
         return LO[DATA_BITS-1:0];
      end
      return r[DATA_BITS-1:0];
   endfunction

   logic signed [TRIG_BITS-1:0] fz;
   logic signed [PW-1:0]        px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic signed [DATA_BITS-1:0] sx_ff, sx_in, sy_ff, sy_in, sz_ff, sz_in;

   assign fz    = cfg_i.forward_z_negative ? -head_cos_i : head_cos_i;
   assign px_in = speed_i * head_sin_i;
   assign py_in = speed_i * pitch_sin_i;
   assign pz_in = speed_i * fz;

   assign sx_in = round_sat(px_ff);
   assign sy_in = cfg_i.pitch_enable ? round_sat(py_ff) : '0;
   assign sz_in = round_sat(pz_ff);

   always_ff @(posedge clock) begin
      px_ff <= px_in;
      py_ff <= py_in;
      pz_ff <= pz_in;
      sx_ff <= sx_in;
      sy_ff <= sy_in;
      sz_ff <= sz_in;
   end

   assign step_x_o = sx_ff;
   assign step_y_o = sy_ff;
   assign step_z_o = sz_ff;

endmodule
`default_nettype wire

>>> design/hpv_rsp_queue.sv
`default_nettype none
module hpv_rsp_queue #(
   parameter int DATA_BITS = 16,
   parameter int DEPTH     = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        admit_i,
   output logic                             space_o,
   input  wire logic                        push_i,
   input  wire logic signed [DATA_BITS-1:0] step_x_i,
   input  wire logic signed [DATA_BITS-1:0] step_y_i,
   input  wire logic signed [DATA_BITS-1:0] step_z_i,
   hpv_rsp_if.source                        rsp
);
   localparam int AW = $clog2(DEPTH);
   localparam int CW = AW + 1;
   localparam int EW = 3 * DATA_BITS;
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   logic [EW-1:0] mem [DEPTH];
   logic [EW-1:0] data_ff;
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] fill_ff, fill_in, credit_ff, credit_in;
   logic          valid_ff, valid_in;
   logic          pop, done;

   assign done = valid_ff & rsp.ready;
   assign pop  = (fill_ff != '0) && (!valid_ff || rsp.ready);

   assign wr_ptr_in = push_i ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign fill_in   = fill_ff + CW'(push_i) - CW'(pop);
   assign credit_in = credit_ff + CW'(admit_i) - CW'(done);
   assign valid_in  = pop | (valid_ff & ~rsp.ready);

   always_ff @(posedge clock) begin
      if (push_i) begin
         mem[wr_ptr_ff] <= {step_x_i, step_y_i, step_z_i};
      end
      if (pop) begin
         data_ff <= mem[rd_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
         credit_ff <= '0;
         valid_ff  <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
         credit_ff <= credit_in;
         valid_ff  <= valid_in;
      end
   end

   assign space_o    = credit_ff < DEPTH_C;
   assign rsp.valid  = valid_ff;
   assign rsp.step_x = data_ff[EW-1 -: DATA_BITS];
   assign rsp.step_y = data_ff[2*DATA_BITS-1 -: DATA_BITS];
   assign rsp.step_z = data_ff[DATA_BITS-1:0];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_i |-> fill_ff < DEPTH_C)
      else $error("result queue written while full");

   a_fill_in_credit: assert property (@(posedge clock) disable iff (reset)
      fill_ff + CW'(valid_ff) <= credit_ff)
      else $error("queued results exceed outstanding transfers");

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= DEPTH_C)
      else $error("outstanding transfers exceed queue depth");

   a_idle_no_valid: assert property (@(posedge clock) disable iff (reset)
      credit_ff == '0 |-> !valid_ff && fill_ff == '0)
      else $error("result shown with nothing outstanding");

endmodule
`default_nettype wire

>>> design/heading_pitch_to_velocity_vector.sv
// Channel   Dir  Payload                                   Transfer when
// req_chan  in   heading_angle, pitch_angle, speed         valid & ready
// rsp_chan  out  step_x, step_y, step_z                    valid & ready
// csr (APB) in   forward_z_negative @0x0, pitch_enable @0x4 psel & penable & pwrite
//
// One transfer per cycle sustained while rsp is ready; the registered steps in order are
// fold, rotation stages, unfold, multiply, round/saturate, queue write, queue read.
// Results go through a queue memory of DEPTH entries; req ready drops once
// DEPTH transfers are outstanding, so rsp stalls back up into req only then.
// Synchronous active-high reset clears pipeline valids and queue pointers.
`default_nettype none
module heading_pitch_to_velocity_vector #(
   parameter int ANGLE_BITS      = 16,
   parameter int DATA_BITS       = 16,
   parameter int ROTATION_STAGES = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   hpv_req_if.sink                                    req_chan,
   hpv_rsp_if.source                                  rsp_chan,
   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic [hpv_pkg::CSR_ADDR_BITS-1:0]     paddr,
   input  wire logic [hpv_pkg::CSR_DATA_BITS-1:0]     pwdata,
   output logic      [hpv_pkg::CSR_DATA_BITS-1:0]     prdata,
   output logic                                       pready
);
   import hpv_pkg::*;

   localparam int TRIG_LAT = ROTATION_STAGES + 2;
   localparam int LATENCY  = TRIG_LAT + 2;
   localparam int DEPTH    = 2 ** $clog2(LATENCY + 4);

   hpv_cfg_type cfg;
   logic        accept, space;

   logic                        vld_ff [LATENCY];
   logic signed [DATA_BITS-1:0] spd_ff [TRIG_LAT];

   logic signed [TRIG_BITS-1:0] head_cos, head_sin, pitch_cos, pitch_sin;
   logic signed [DATA_BITS-1:0] step_x, step_y, step_z;

   assign accept         = req_chan.valid & space;
   assign req_chan.ready = space;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LATENCY; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= accept;
         for (int i = 1; i < LATENCY; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      spd_ff[0] <= req_chan.speed;
      for (int i = 1; i < TRIG_LAT; i++) begin
         spd_ff[i] <= spd_ff[i-1];
      end
   end

   hpv_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg_o   (cfg)
   );

   hpv_cordic #(
      .ANGLE_BITS      (ANGLE_BITS),
      .ROTATION_STAGES (ROTATION_STAGES)
   ) u_head (
      .clock   (clock),
      .angle_i (req_chan.heading_angle),
      .cos_o   (head_cos),
      .sin_o   (head_sin)
   );

   hpv_cordic #(
      .ANGLE_BITS      (ANGLE_BITS),
      .ROTATION_STAGES (ROTATION_STAGES)
   ) u_pitch (
      .clock   (clock),
      .angle_i (req_chan.pitch_angle),
      .cos_o   (pitch_cos),
      .sin_o   (pitch_sin)
   );

   hpv_scale #(
      .DATA_BITS (DATA_BITS)
   ) u_scale (
      .clock       (clock),
      .cfg_i       (cfg),
      .speed_i     (spd_ff[TRIG_LAT-1]),
      .head_cos_i  (head_cos),
      .head_sin_i  (head_sin),
      .pitch_sin_i (pitch_sin),
      .step_x_o    (step_x),
      .step_y_o    (step_y),
      .step_z_o    (step_z)
   );

   hpv_rsp_queue #(
      .DATA_BITS (DATA_BITS),
      .DEPTH     (DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .admit_i  (accept),
      .space_o  (space),
      .push_i   (vld_ff[LATENCY-1]),
      .step_x_i (step_x),
      .step_y_i (step_y),
      .step_z_i (step_z),
      .rsp      (rsp_chan)
   );

   a_pitch_cos_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[TRIG_LAT-1] |-> (pitch_cos[TRIG_BITS-1:PHASE_BITS-1] == '0) ||
                             (pitch_cos[TRIG_BITS-1:PHASE_BITS-1] == '1))
      else $error("pitch cosine outside unit range");

   a_push_follows_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> vld_ff[0])
      else $error("accepted transfer lost at pipeline entry");

   a_push_has_credit: assert property (@(posedge clock) disable iff (reset)
      vld_ff[LATENCY-1] |-> !space || req_chan.ready)
      else $error("result produced without ready tracking");

endmodule
`default_nettype wire
